// ----- rtl/isort_pkg.sv -----
// Shared types and constants for the insertion sorter.
package isort_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;

    // Sorter phase: collect a batch, or stream it out
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast value
        logic shift;  // move every entry one cell toward the output
    } t_cell_ctl;

endpackage

// ----- rtl/insertion_sorter_core.sv -----
// Top level of the batch insertion sorter: cell chain, control and output register.
//
// Input stream: one signed 32-bit value per transaction on i_s_tdata, with
// i_s_tlast high on the final value of a batch. Every value drops into a
// chain of DEPTH cells: each cell compares against the
// broadcast value and either keeps its entry, takes its neighbor's entry or
// takes the new value, so the chain stays in ascending order with equal
// values in arrival order. Values beyond DEPTH are discarded and the batch
// is flagged.
// After the transaction carrying tlast, o_s_tready drops and the chain
// shifts its entries out toward the output, one per cycle, while the output
// register is free or being taken. Each result carries o_m_tlast on the
// largest entry and o_m_tuser high if the batch lost values. The first
// result is loaded into the output register after the tlast transaction
// has moved the state register to draining; at most DEPTH values of a
// batch are stored and drained. An output stall freezes the chain.
// o_s_tready returns the cycle after the final result is loaded, even
// while it waits in the output register.
// Reset (synchronous, active low) empties the chain and the output register.
module insertion_sorter_core #(
    parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [isort_pkg::DATA_W-1:0]      i_s_tdata,   // [31:0] value
    input  logic                              i_s_tlast,   // last
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [isort_pkg::DATA_W-1:0]      o_m_tdata,   // [31:0] sorted_value
    output logic                              o_m_tlast,   // final_res
    output logic                              o_m_tuser    // [0] dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DW    = isort_pkg::DATA_W;

    isort_pkg::t_state    r_state, n_state;
    isort_pkg::t_cell_ctl ctl;

    logic [CNT_W-1:0]       r_count;
    logic                   r_ovf;
    logic                   r_out_vld;
    logic [DW-1:0]          r_out_data;
    logic                   r_out_last;
    logic                   r_out_user;

    logic signed [DW-1:0]   cell_data [DEPTH];
    logic                   cell_vld  [DEPTH];
    logic                   cell_gt   [DEPTH];

    logic                   s_acc;
    logic                   full;
    logic                   load;
    logic                   final_load;

    assign full       = cell_vld[DEPTH-1];
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign load       = (r_state == isort_pkg::ST_DRAIN) && (!r_out_vld || i_m_tready);
    assign final_load = load && (r_count == CNT_W'(1));

    assign ctl.ins    = s_acc && !full;
    assign ctl.shift  = load;

    // Build the chain; each cell talks only to its two neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DW-1:0] prev_data;
        logic                 prev_gt;
        logic                 prev_vld;
        logic signed [DW-1:0] next_data;
        logic                 next_vld;

        if (i == 0) begin : g_head
            assign prev_data = $signed(i_s_tdata);
            assign prev_gt   = 1'b0;
            assign prev_vld  = 1'b1;
        end else begin : g_body
            assign prev_data = cell_data[i-1];
            assign prev_gt   = cell_gt[i-1];
            assign prev_vld  = cell_vld[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_data = '0;
            assign next_vld  = 1'b0;
        end else begin : g_inner
            assign next_data = cell_data[i+1];
            assign next_vld  = cell_vld[i+1];
        end

        isort_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_value     ($signed(i_s_tdata)),
            .i_prev_data (prev_data),
            .i_prev_gt   (prev_gt),
            .i_prev_vld  (prev_vld),
            .i_next_data (next_data),
            .i_next_vld  (next_vld),
            .o_data      (cell_data[i]),
            .o_vld       (cell_vld[i]),
            .o_gt        (cell_gt[i])
        );
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isort_pkg::ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input ready
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        unique case (r_state)
            isort_pkg::ST_FILL: begin
                o_s_tready = 1'b1;
                if (s_acc && i_s_tlast) begin
                    n_state = isort_pkg::ST_DRAIN;
                end
            end
            isort_pkg::ST_DRAIN: begin
                if (final_load) begin
                    n_state = isort_pkg::ST_FILL;
                end
            end
            default: n_state = isort_pkg::ST_FILL;
        endcase
    end

    // Count stored entries while filling, remaining ones while draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (ctl.ins) begin
            r_count <= r_count + CNT_W'(1);
        end else if (load) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Flag a batch that overran the chain; clear once its last result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (s_acc && full) begin
            r_ovf <= 1'b1;
        end else if (final_load) begin
            r_ovf <= 1'b0;
        end
    end

    // Output register: load from the chain head, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= cell_data[0];
            r_out_last <= (r_count == CNT_W'(1));
            r_out_user <= r_ovf;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

// ----- rtl/isort_cell.sv -----
// One storage cell of the systolic insertion chain.
module isort_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  isort_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [isort_pkg::DATA_W-1:0]    i_value,
    input  logic signed [isort_pkg::DATA_W-1:0]    i_prev_data,
    input  logic                                   i_prev_gt,
    input  logic                                   i_prev_vld,
    input  logic signed [isort_pkg::DATA_W-1:0]    i_next_data,
    input  logic                                   i_next_vld,
    output logic signed [isort_pkg::DATA_W-1:0]    o_data,
    output logic                                   o_vld,
    output logic                                   o_gt
);

    logic signed [isort_pkg::DATA_W-1:0] r_data;
    logic                                r_vld;
    logic                                take;

    // An empty cell counts as larger than any value; equal entries stay put
    assign o_gt   = !r_vld || (r_data > i_value);
    assign o_data = r_data;
    assign o_vld  = r_vld;

    // Move only when something valid arrives: the new value or a real upper entry
    assign take   = i_ctl.ins && o_gt && (!i_prev_gt || i_prev_vld);

    // Hold the valid flag; insert or shift toward the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_next_vld;
        end else if (take) begin
            r_vld <= 1'b1;
        end
    end

    // Take the lower neighbor's entry if it also moves up, else the new value
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_next_data;
        end else if (take) begin
            r_data <= i_prev_gt ? i_prev_data : i_value;
        end
    end

endmodule

// ----- rtl/isort_checker.sv -----
// Port-level checker for the insertion sorter, bound to the top level.
module isort_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          i_s_tlast,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [isort_pkg::DATA_W-1:0]  o_m_tdata
);

    // Reset leaves the block empty and ready for a new batch
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_tready && !o_m_tvalid))
        else $error("block not idle after reset");

    // The end of a batch stops intake while the sorted run drains
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still ready after end of batch");

    // A value inside a batch never stops intake
    a_fill_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tlast) |=> o_s_tready)
        else $error("input stalled in the middle of a batch");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output transaction changed");

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for insertion_sorter_core: directed table, then random batches.
module tb;

    localparam int DEPTH       = isort_pkg::DEPTH_DEF;
    localparam int DW          = isort_pkg::DATA_W;
    localparam int PHASE_ITEMS = 40;

    // One emitted element: value, final marker, lost-values flag
    typedef struct packed {
        logic [DW-1:0] value;
        logic          final_res;
        logic          dropped;
    } t_sorted_word;

    // Directed stimulus row; want is used only where typed is set
    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        logic          typed;
        t_sorted_word  want;
    } t_stim_row;

    localparam int N_ROWS = 15;
    localparam t_stim_row STIM_TAB [N_ROWS] = '{
        // single-value batches at the extremes
        '{32'h7fff_ffff, 1'b1, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b0}},
        '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 1'b1, 1'b0}},
        // mixed signs, duplicates and extremes in one batch
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h7fff_ffff, 1'b0, 1'b0, '0},
        '{32'hffff_ffff, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b1, 1'b0, '0},
        // already in order
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h7fff_ffff, 1'b1, 1'b0, '0},
        // reverse order
        '{32'h0000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b1, 1'b0, '0}
    };

    // Batch sizes that open each phase: full, one over, several over, one over
    localparam int OVER_LEN [4] = '{DEPTH, DEPTH + 1, DEPTH + 4, DEPTH + 1};
    localparam int SRC_IDLE [4] = '{0, 48, 0, 10};
    localparam int SNK_STALL [4] = '{0, 0, 48, 10};

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [DW-1:0] i_s_tdata  = '0;    // [31:0] value
    logic          i_s_tlast  = 1'b0;  // last
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [DW-1:0] o_m_tdata;          // [31:0] sorted_value
    logic          o_m_tlast;          // final_res
    logic          o_m_tuser;          // [0] dropped

    // Shadow of the sorter chain
    logic signed [DW-1:0] shadow_store [DEPTH];
    int                   shadow_cnt  = 0;
    logic                 shadow_lost = 1'b0;

    t_sorted_word sorted_due [$];
    t_sorted_word due_word;
    int           err_cnt       = 0;
    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;

    insertion_sorter_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #1_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        err_cnt++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // Insert one value into the shadow chain; on last, queue the sorted batch if keep is set
    function automatic void insert_and_emit(input logic signed [DW-1:0] v, input logic l,
                                            input logic keep);
        int pos;
        int k;
        if (shadow_cnt >= DEPTH) begin
            shadow_lost = 1'b1;
        end else begin
            pos = shadow_cnt;
            while (pos > 0 && shadow_store[pos-1] > v) begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = v;
            shadow_cnt++;
        end
        if (l) begin
            if (keep) begin
                for (k = 0; k < shadow_cnt; k++)
                    sorted_due.push_back('{shadow_store[k], k + 1 == shadow_cnt, shadow_lost});
            end
            shadow_cnt  = 0;
            shadow_lost = 1'b0;
        end
    endfunction

    // Spread values over extremes, small ranges with duplicates and full random
    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 7) - 4;
            3:       return 32'h7fff_ffff - $urandom_range(0, 2);
            4:       return 32'h8000_0000 + $urandom_range(0, 2);
            default: return {$urandom_range(0, 1) == 1 ? 1'b1 : 1'b0, 31'($urandom_range(0, 15))};
        endcase
    endfunction

    // Present one value after a random gap and hold it until the transaction completes
    task automatic send_value(input logic [DW-1:0] v, input logic l, input logic typed,
                              input t_sorted_word want);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        insert_and_emit(v, l, !typed);
        if (typed)
            sorted_due.push_back(want);
    endtask

    task automatic send_batch(input int len);
        int n;
        for (n = 0; n < len; n++)
            send_value(pick_value(), n == len - 1, 1'b0, '0);
    endtask

    // Drop valid and wait until every queued result has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sorted_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Check each result transaction against the oldest expectation; randomize ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sorted_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                due_word = sorted_due.pop_front();
                if (o_m_tdata !== due_word.value)
                    flag_mismatch($sformatf("value %h, want %h", o_m_tdata, due_word.value));
                if (o_m_tlast !== due_word.final_res)
                    flag_mismatch($sformatf("tlast %b, want %b on %h", o_m_tlast,
                                            due_word.final_res, due_word.value));
                if (o_m_tuser !== due_word.dropped)
                    flag_mismatch($sformatf("tuser %b, want %b on %h", o_m_tuser,
                                            due_word.dropped, due_word.value));
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Stimulus: reset, directed table, then random batches over idling phases
    initial begin
        int r;
        int ph;
        int sent;
        int len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_ROWS; r++)
            send_value(STIM_TAB[r].value, STIM_TAB[r].last, STIM_TAB[r].typed, STIM_TAB[r].want);

        for (ph = 0; ph < 4; ph++) begin
            drain_results();
            src_idle_pct  = SRC_IDLE[ph];
            snk_stall_pct = SNK_STALL[ph];
            send_batch(OVER_LEN[ph]);
            sent = OVER_LEN[ph];
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(DEPTH - 1, DEPTH + 3);
                else
                    len = $urandom_range(1, 8);
                send_batch(len);
                sent += len;
            end
        end

        drain_results();
        repeat (3 * DEPTH) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/insertion_sorter_core.sv
rtl/isort_checker.sv
verif/tb.sv
